>>> sv/calendar_date_span_days_core_assert.svh
// assertion macros for the calendar date span core
// expects signals named clock and reset in the module that uses them
`ifndef CALENDAR_DATE_SPAN_DAYS_CORE_ASSERT_SVH
`define CALENDAR_DATE_SPAN_DAYS_CORE_ASSERT_SVH

// consequent must hold in the same cycle
`define CDSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cdsd check failed in same cycle");

// consequent must hold in the following cycle
`define CDSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cdsd check failed in next cycle");

`endif

>>> sv/cdsd_pkg.sv
// shared types, constants and calendar helpers for the date span core
// no dependencies
`timescale 1ns / 1ps

package cdsd_pkg;

   localparam int DayW    = 5;
   localparam int MonthW  = 4;
   localparam int YearW   = 12;
   localparam int SpanW   = 20;
   localparam int DayNumW = 21;
   localparam int QuartW  = YearW - 2;
   localparam int CentW   = 6;
   localparam int OffsetW = 9;

   localparam logic [YearW-1:0]  YearMin  = 12'd1900;
   localparam logic [MonthW-1:0] MonthJan = 4'd1;
   localparam logic [MonthW-1:0] MonthFeb = 4'd2;
   localparam logic [MonthW-1:0] MonthDec = 4'd12;

   // x / 25 for x below 1024 as (x * 1311) >> 15
   localparam int            Div25Shift = 15;
   localparam logic [10:0]   Div25Mul   = 11'd1311;
   localparam logic [8:0]    DaysPerYear = 9'd365;

   typedef struct packed {
      logic                ok;
      logic [DayNumW-1:0]  day_num;
   } date_result_type;

   function automatic logic [CentW-1:0] div25(input logic [QuartW-1:0] x);
      logic [QuartW+10:0] prod;
      prod = {11'b0, x} * {10'b0, Div25Mul};
      return prod[Div25Shift +: CentW];
   endfunction

   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
      logic [DayW-1:0] len;
      case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // days from 1 march to the first of the month, year starting in march
   function automatic logic [OffsetW-1:0] month_offset(input logic [MonthW-1:0] m);
      logic [OffsetW-1:0] off;
      case (m)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

>>> sv/calendar_date_span_days_core.sv
// inclusive day span between two gregorian dates, with per-date validity flags
// the input stage registers the request word, the result stage then registers the result word
// throughput: one word per cycle unless rsp_ready holds the input and result register stages
// reset (synchronous, active high) empties both stages; payload registers are not reset
// depends on cdsd_pkg, cdsd_date_unit and calendar_date_span_days_core_assert.svh
`timescale 1ns / 1ps

`include "calendar_date_span_days_core_assert.svh"

module calendar_date_span_days_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cdsd_pkg::DayW-1:0]     req_start_day,
   input  logic [cdsd_pkg::MonthW-1:0]   req_start_month,
   input  logic [cdsd_pkg::YearW-1:0]    req_start_year,
   input  logic [cdsd_pkg::DayW-1:0]     req_end_day,
   input  logic [cdsd_pkg::MonthW-1:0]   req_end_month,
   input  logic [cdsd_pkg::YearW-1:0]    req_end_year,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cdsd_pkg::SpanW-1:0]    rsp_span_days,
   output logic                          rsp_start_ok,
   output logic                          rsp_end_ok
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [cdsd_pkg::DayW-1:0]     s1_start_day_ff;
   logic [cdsd_pkg::MonthW-1:0]   s1_start_month_ff;
   logic [cdsd_pkg::YearW-1:0]    s1_start_year_ff;
   logic [cdsd_pkg::DayW-1:0]     s1_end_day_ff;
   logic [cdsd_pkg::MonthW-1:0]   s1_end_month_ff;
   logic [cdsd_pkg::YearW-1:0]    s1_end_year_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cdsd_pkg::SpanW-1:0]    rsp_span_days_ff, rsp_span_days_in;
   logic                          rsp_start_ok_ff;
   logic                          rsp_end_ok_ff;

   logic                          out_free;
   logic                          req_take;
   logic                          s1_move;

   cdsd_pkg::date_result_type     start_res;
   cdsd_pkg::date_result_type     end_res;
   logic [cdsd_pkg::DayNumW-1:0]  num_diff;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;
   assign s1_move   = s1_valid_ff && out_free;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_start_day_ff   <= req_start_day;
         s1_start_month_ff <= req_start_month;
         s1_start_year_ff  <= req_start_year;
         s1_end_day_ff     <= req_end_day;
         s1_end_month_ff   <= req_end_month;
         s1_end_year_ff    <= req_end_year;
      end
   end

   cdsd_date_unit u_start_date (
      .day    (s1_start_day_ff),
      .month  (s1_start_month_ff),
      .year   (s1_start_year_ff),
      .result (start_res)
   );

   cdsd_date_unit u_end_date (
      .day    (s1_end_day_ff),
      .month  (s1_end_month_ff),
      .year   (s1_end_year_ff),
      .result (end_res)
   );

   // inclusive count, zero when either date fails or end is earlier
   assign num_diff = end_res.day_num - start_res.day_num;

   always_comb begin
      rsp_span_days_in = '0;
      if (start_res.ok && end_res.ok && (end_res.day_num >= start_res.day_num)) begin
         rsp_span_days_in = num_diff[cdsd_pkg::SpanW-1:0] + cdsd_pkg::SpanW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_span_days_ff <= rsp_span_days_in;
         rsp_start_ok_ff  <= start_res.ok;
         rsp_end_ok_ff    <= end_res.ok;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_span_days = rsp_span_days_ff;
   assign rsp_start_ok  = rsp_start_ok_ff;
   assign rsp_end_ok    = rsp_end_ok_ff;

   `CDSD_ASSERT_NOW(a_invalid_gives_zero, rsp_valid_ff && !(rsp_start_ok_ff && rsp_end_ok_ff), rsp_span_days_ff == '0)
   `CDSD_ASSERT_NEXT(a_taken_word_held, req_valid && req_ready, s1_valid_ff)
   `CDSD_ASSERT_NEXT(a_stalled_stage_holds, s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_start_year_ff) && $stable(s1_end_year_ff))
   `CDSD_ASSERT_NEXT(a_stage_advances, s1_valid_ff && out_free, rsp_valid_ff)

endmodule

>>> sv/cdsd_date_unit.sv
// checks one gregorian date and converts it to a day number from 1 march of year 0
// depends on cdsd_pkg
`timescale 1ns / 1ps

module cdsd_date_unit (
   input  logic [cdsd_pkg::DayW-1:0]   day,
   input  logic [cdsd_pkg::MonthW-1:0] month,
   input  logic [cdsd_pkg::YearW-1:0]  year,
   output cdsd_pkg::date_result_type   result
);

   logic [cdsd_pkg::QuartW-1:0] quart;
   logic [cdsd_pkg::CentW-1:0]  cent;
   logic [cdsd_pkg::QuartW-1:0] cent_x25;
   logic                        is_century;
   logic                        leap;
   logic [cdsd_pkg::DayW-1:0]   lim;
   logic                        early_month;
   logic [cdsd_pkg::YearW-1:0]  adj_year;
   logic [cdsd_pkg::QuartW-1:0] adj_quart;
   logic [cdsd_pkg::CentW-1:0]  adj_cent;

   // leap year from the real year
   assign quart      = year[cdsd_pkg::YearW-1:2];
   assign cent       = cdsd_pkg::div25(quart);
   assign cent_x25   = {cent, 4'b0} + {1'b0, cent, 3'b0} + {4'b0, cent};
   assign is_century = (year[1:0] == 2'b00) && (quart == cent_x25);
   assign leap       = (year[1:0] == 2'b00) && (!is_century || (cent[1:0] == 2'b00));

   assign lim = cdsd_pkg::month_len(month, leap);

   assign result.ok = (year >= cdsd_pkg::YearMin) && (month >= cdsd_pkg::MonthJan)
                    && (month <= cdsd_pkg::MonthDec) && (day != '0) && (day <= lim);

   // january and february count as months of the previous year
   assign early_month = (month <= cdsd_pkg::MonthFeb);
   assign adj_year    = early_month ? (year - cdsd_pkg::YearW'(1)) : year;
   assign adj_quart   = adj_year[cdsd_pkg::YearW-1:2];
   assign adj_cent    = cdsd_pkg::div25(adj_quart);

   assign result.day_num =
        cdsd_pkg::DayNumW'(adj_year) * cdsd_pkg::DayNumW'(cdsd_pkg::DaysPerYear)
      + cdsd_pkg::DayNumW'(adj_quart)
      - cdsd_pkg::DayNumW'(adj_cent)
      + cdsd_pkg::DayNumW'(adj_cent[cdsd_pkg::CentW-1:2])
      + cdsd_pkg::DayNumW'(cdsd_pkg::month_offset(month))
      + cdsd_pkg::DayNumW'(day)
      - cdsd_pkg::DayNumW'(1);

endmodule
